### rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants, codes and types of the servo status packet deframer.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Parameter buffer depth and derived widths
  localparam int MAX_PARAMS = 32;
  localparam int RES_CAP    = 32;
  localparam int IDX_W      = $clog2(MAX_PARAMS);
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1);

  localparam logic [7:0] HDR_BYTE     = 8'hFF;
  localparam logic [7:0] MIN_LEN      = 8'd2;
  localparam logic [8:0] LEN_OVERHEAD = 9'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_EXPECTED_ID   = 2'd0;
  localparam logic [1:0] CFG_MAX_TOTAL_LEN = 2'd1;
  localparam logic [1:0] CFG_REQUESTED_LEN = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_CHECKSUM  = 3'd4;
  localparam logic [2:0] ST_ID_MISM   = 3'd5;
  localparam logic [2:0] ST_SERVO_ERR = 3'd6;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [4:0] param_index;
    logic [2:0] status_code;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
    logic [5:0] param_count;
    logic       last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic       ld_id;
    logic       ld_len;
    logic       ld_err;
    logic       ld_param;
    logic       clr_sum;
    logic       emit_clr;
    logic       emit_inc;
    logic       push;
    logic       push_param;
    logic [2:0] push_code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_ff;
    logic too_long;
    logic short_len;
    logic no_params;
    logic last_param;
    logic csum_ok;
    logic id_ok;
    logic err_zero;
    logic emit_done;
    logic fifo_full;
  } sts_t;

endpackage

### rtl/ssd_ram.sv
// ----------------------------------------------------------------------------
// ssd_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ssd_ctrl.sv
// ----------------------------------------------------------------------------
// ssd_ctrl
// Packet phase sequencer: walks the header, id, length, error, parameter and
// checksum bytes, then drives the parameter burst and the final status.
// ----------------------------------------------------------------------------
module ssd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ssd_pkg::sts_t sts,
  output ssd_pkg::cmd_t cmd
);
  import ssd_pkg::*;

  localparam logic [3:0] S_HDR1      = 4'd0;
  localparam logic [3:0] S_HDR2      = 4'd1;
  localparam logic [3:0] S_ID        = 4'd2;
  localparam logic [3:0] S_LEN       = 4'd3;
  localparam logic [3:0] S_ERR       = 4'd4;
  localparam logic [3:0] S_PARAM     = 4'd5;
  localparam logic [3:0] S_CSUM      = 4'd6;
  localparam logic [3:0] S_EMIT_WAIT = 4'd7;
  localparam logic [3:0] S_EMIT_PUSH = 4'd8;
  localparam logic [3:0] S_STATUS    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       rx_phase;
  logic       accept;

  assign rx_phase = (state_r <= S_CSUM);
  assign in_stall = !(rx_phase && !sts.fifo_full);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_HDR1: begin
        if (accept) begin
          if (sts.is_ff) begin
            state_nxt = S_HDR2;
          end else begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_BAD_HDR;
          end
        end
      end
      S_HDR2: begin
        if (accept) begin
          if (sts.is_ff) begin
            cmd.clr_sum = 1'b1;
            state_nxt   = S_ID;
          end else begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_BAD_HDR;
            state_nxt     = S_HDR1;
          end
        end
      end
      S_ID: begin
        if (accept) begin
          cmd.ld_id = 1'b1;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          cmd.ld_len = 1'b1;
          if (sts.too_long) begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_TOO_LONG;
            state_nxt     = S_HDR1;
          end else if (sts.short_len) begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_BAD_LEN;
            state_nxt     = S_HDR1;
          end else begin
            state_nxt = S_ERR;
          end
        end
      end
      S_ERR: begin
        if (accept) begin
          cmd.ld_err = 1'b1;
          state_nxt  = sts.no_params ? S_CSUM : S_PARAM;
        end
      end
      S_PARAM: begin
        if (accept) begin
          cmd.ld_param = 1'b1;
          if (sts.last_param) begin
            state_nxt = S_CSUM;
          end
        end
      end
      S_CSUM: begin
        if (accept) begin
          if (!sts.csum_ok) begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_CHECKSUM;
            state_nxt     = S_HDR1;
          end else if (!sts.id_ok) begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_ID_MISM;
            state_nxt     = S_HDR1;
          end else if (!sts.err_zero) begin
            cmd.push      = 1'b1;
            cmd.push_code = ST_SERVO_ERR;
            state_nxt     = S_HDR1;
          end else begin
            cmd.emit_clr = 1'b1;
            state_nxt    = S_EMIT_WAIT;
          end
        end
      end
      S_EMIT_WAIT: begin
        // wait here for the registered buffer read to land
        state_nxt = sts.emit_done ? S_STATUS : S_EMIT_PUSH;
      end
      S_EMIT_PUSH: begin
        if (!sts.fifo_full) begin
          cmd.push       = 1'b1;
          cmd.push_param = 1'b1;
          cmd.push_code  = ST_OK;
          cmd.emit_inc   = 1'b1;
          state_nxt      = S_EMIT_WAIT;
        end
      end
      S_STATUS: begin
        if (!sts.fifo_full) begin
          cmd.push      = 1'b1;
          cmd.push_code = ST_OK;
          state_nxt     = S_HDR1;
        end
      end
      default: begin
        state_nxt = S_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HDR1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/ssd_dp.sv
// ----------------------------------------------------------------------------
// ssd_dp
// Datapath: configuration registers, packet fields, running sum, parameter
// buffer and a two-word result queue in front of the output.
// ----------------------------------------------------------------------------
module ssd_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic [7:0]    in_rx_byte,
  input  ssd_pkg::cmd_t cmd,
  output ssd_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output ssd_pkg::res_t res
);
  import ssd_pkg::*;

  logic [7:0]       exp_id_r, max_len_r;
  logic [5:0]       req_len_r;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       err_r, err_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] emit_r, emit_nxt;
  logic [CNT_W-1:0] pos_inc;
  logic [7:0]       len_m2;
  logic [7:0]       n_a;
  logic [CNT_W-1:0] nparams;
  logic [7:0]       ram_rdata;

  res_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  res_t       push_word;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r  <= 8'd1;
      max_len_r <= 8'd64;
      req_len_r <= 6'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_ID:   exp_id_r  <= cfg_data;
        CFG_MAX_TOTAL_LEN: max_len_r <= cfg_data;
        CFG_REQUESTED_LEN: req_len_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Packet fields
  assign pos_inc = pos_r + 1'b1;
  assign len_m2  = len_r - MIN_LEN;

  always_comb begin
    sum_nxt  = sum_r;
    id_nxt   = id_r;
    len_nxt  = len_r;
    err_nxt  = err_r;
    pos_nxt  = pos_r;
    emit_nxt = emit_r;
    if (cmd.clr_sum) begin
      sum_nxt = '0;
    end
    if (cmd.ld_id || cmd.ld_len || cmd.ld_err || cmd.ld_param) begin
      sum_nxt = sum_r + in_rx_byte;
    end
    if (cmd.ld_id) begin
      id_nxt  = in_rx_byte;
      err_nxt = '0;
    end
    if (cmd.ld_len) begin
      len_nxt = in_rx_byte;
    end
    if (cmd.ld_err) begin
      err_nxt = in_rx_byte;
      pos_nxt = '0;
    end
    if (cmd.ld_param) begin
      pos_nxt = pos_inc;
    end
    if (cmd.emit_clr) begin
      emit_nxt = '0;
    end else if (cmd.emit_inc) begin
      emit_nxt = emit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      id_r   <= '0;
      len_r  <= '0;
      err_r  <= '0;
      pos_r  <= '0;
      emit_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      id_r   <= id_nxt;
      len_r  <= len_nxt;
      err_r  <= err_nxt;
      pos_r  <= pos_nxt;
      emit_r <= emit_nxt;
    end
  end

  // Returned count: least of received, requested and cap
  always_comb begin
    n_a = len_m2;
    if (8'(req_len_r) < n_a) begin
      n_a = 8'(req_len_r);
    end
    if (n_a > 8'(RES_CAP)) begin
      n_a = 8'(RES_CAP);
    end
    if (n_a > 8'(MAX_PARAMS)) begin
      n_a = 8'(MAX_PARAMS);
    end
    nparams = n_a[CNT_W-1:0];
  end

  ssd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PARAMS)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.ld_param),
    .waddr (pos_r[IDX_W-1:0]),
    .wdata (in_rx_byte),
    .raddr (emit_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Status toward the controller
  always_comb begin
    sts            = '0;
    sts.is_ff      = (in_rx_byte == HDR_BYTE);
    sts.too_long   = ((9'(in_rx_byte) + LEN_OVERHEAD) > 9'(max_len_r)) ||
                     (in_rx_byte > 8'(MAX_PARAMS + 2));
    sts.short_len  = (in_rx_byte < MIN_LEN);
    sts.no_params  = (len_r == MIN_LEN);
    sts.last_param = (8'(pos_inc) >= len_m2);
    sts.csum_ok    = (in_rx_byte == ~sum_r);
    sts.id_ok      = (id_r == exp_id_r);
    sts.err_zero   = (err_r == 8'd0);
    sts.emit_done  = (emit_r == nparams);
    sts.fifo_full  = (cnt_r == 2'd2);
  end

  // Result word assembly
  always_comb begin
    push_word = '0;
    if (cmd.push_param) begin
      push_word.kind        = 1'b0;
      push_word.data_byte   = ram_rdata;
      push_word.param_index = 5'(emit_r);
      push_word.status_code = ST_OK;
      push_word.servo_id    = id_r;
      push_word.param_count = 6'(nparams);
    end else begin
      push_word.kind        = 1'b1;
      push_word.status_code = cmd.push_code;
      push_word.servo_id    = (cmd.push_code == ST_BAD_HDR) ? 8'd0 : id_r;
      push_word.servo_error = (cmd.push_code == ST_BAD_HDR) ? 8'd0 : err_r;
      push_word.param_count = (cmd.push_code == ST_OK) ? 6'(nparams) : 6'd0;
      push_word.last        = 1'b1;
    end
  end

  // Two-word output queue
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign res       = fifo_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!cmd.push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      fifo_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

### rtl/servo_status_packet_deframer.sv
// ----------------------------------------------------------------------------
// servo_status_packet_deframer
// Parses status packets (FF FF id length error params checksum) from a
// received byte stream and returns parameter words plus one status word.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while a packet is being parsed, as
// long as the two-word output queue has room; a bad header byte, an
// oversized or short length, and a failing checksum, id or servo error each
// queue a single status word in the cycle the byte is taken, and the next
// byte can be taken while that status word still waits on the output.
// After a good checksum the input stalls for the parameter burst: each
// parameter word is first read from the registered buffer and then
// queued, the closing status word follows, and the output side can stall
// the burst. The user must write configuration only while no packet is in
// flight; the block itself does not enforce this.
module servo_status_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // received bytes
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [4:0] out_param_index,
  output logic [2:0] out_status_code,
  output logic [7:0] out_servo_id,
  output logic [7:0] out_servo_error,
  output logic [5:0] out_param_count,
  output logic       out_last
);
  import ssd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  // Sequencer: owns the packet phase and the burst steps
  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: fields, sum, buffer and output queue
  ssd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_rx_byte (in_rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  // Unpack the head word onto the ports
  assign out_kind        = res.kind;
  assign out_data_byte   = res.data_byte;
  assign out_param_index = res.param_index;
  assign out_status_code = res.status_code;
  assign out_servo_id    = res.servo_id;
  assign out_servo_error = res.servo_error;
  assign out_param_count = res.param_count;
  assign out_last        = res.last;

  // Never queue a word into a full output queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.fifo_full)
    else $error("result queued while output queue full");

  // Input is held off whenever the queue is full
  a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fifo_full |-> in_stall)
    else $error("input open while output queue full");

  // A parameter word always sits below its returned count
  a_param_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind) |-> (6'(out_param_index) < out_param_count && !out_last))
    else $error("parameter word index out of range");

  // A failed packet returns no parameters
  a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind && out_status_code != ST_OK) |-> (out_param_count == 6'd0))
    else $error("failed packet reports nonzero count");

endmodule

### test/ssd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_checker
// Watches the byte and result channels of the status packet deframer,
// mirrors its register writes, predicts every result word and compares.
// ----------------------------------------------------------------------------
module ssd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_kind,
  input  logic [7:0] out_data_byte,
  input  logic [4:0] out_param_index,
  input  logic [2:0] out_status_code,
  input  logic [7:0] out_servo_id,
  input  logic [7:0] out_servo_error,
  input  logic [5:0] out_param_count,
  input  logic       out_last,
  output int         fail_count,
  output int         awaited_count,
  output logic       hunting
);
  import ssd_pkg::*;

  typedef enum logic [2:0] {
    HUNT_FF1, HUNT_FF2, GET_ID, GET_LEN, GET_ERR, GET_PARAM, GET_CSUM
  } parse_phase_t;

  // mirrored registers
  logic [7:0]   want_id;
  logic [7:0]   max_len;
  logic [5:0]   req_len;

  // parser state
  parse_phase_t phase;
  logic [7:0]   pos;
  logic [7:0]   sum;
  logic [7:0]   rx_id;
  logic [7:0]   rx_len;
  logic [7:0]   rx_err;
  logic [7:0]   param_buf [MAX_PARAMS];

  res_t         awaited_words [$];

  task automatic close_packet(input logic [2:0] code, input logic [7:0] id,
                              input logic [7:0] err, input logic [5:0] count);
    res_t w;
    w             = '0;
    w.kind        = 1'b1;
    w.status_code = code;
    w.servo_id    = id;
    w.servo_error = err;
    w.param_count = count;
    w.last        = 1'b1;
    awaited_words.push_back(w);
    phase = HUNT_FF1;
    pos   = '0;
    sum   = '0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int   n;
    int   k;
    res_t w;
    case (phase)
      HUNT_FF1: begin
        if (b != HDR_BYTE) close_packet(ST_BAD_HDR, 8'd0, 8'd0, 6'd0);
        else phase = HUNT_FF2;
      end
      HUNT_FF2: begin
        if (b != HDR_BYTE) begin
          close_packet(ST_BAD_HDR, 8'd0, 8'd0, 6'd0);
        end else begin
          phase = GET_ID;
          sum   = '0;
          pos   = '0;
        end
      end
      GET_ID: begin
        rx_id  = b;
        rx_err = '0;
        sum    = sum + b;
        phase  = GET_LEN;
      end
      GET_LEN: begin
        rx_len = b;
        sum    = sum + b;
        // total length adds the two header bytes, the id and the length byte
        if (int'(b) + 4 > int'(max_len) || (b >= MIN_LEN && int'(b) - 2 > MAX_PARAMS))
          close_packet(ST_TOO_LONG, rx_id, 8'd0, 6'd0);
        else if (b < MIN_LEN)
          close_packet(ST_BAD_LEN, rx_id, 8'd0, 6'd0);
        else
          phase = GET_ERR;
      end
      GET_ERR: begin
        rx_err = b;
        sum    = sum + b;
        pos    = '0;
        phase  = (rx_len == MIN_LEN) ? GET_CSUM : GET_PARAM;
      end
      GET_PARAM: begin
        if (int'(pos) < MAX_PARAMS) param_buf[pos[4:0]] = b;
        sum = sum + b;
        pos = pos + 8'd1;
        if (int'(pos) >= int'(rx_len) - 2) phase = GET_CSUM;
      end
      default: begin
        // checksum first, then id, then the servo's own error byte
        if (b != ~sum) begin
          close_packet(ST_CHECKSUM, rx_id, rx_err, 6'd0);
        end else if (rx_id != want_id) begin
          close_packet(ST_ID_MISM, rx_id, rx_err, 6'd0);
        end else if (rx_err != 8'd0) begin
          close_packet(ST_SERVO_ERR, rx_id, rx_err, 6'd0);
        end else begin
          n = int'(rx_len) - 2;
          if (n > int'(req_len)) n = int'(req_len);
          if (n > RES_CAP) n = RES_CAP;
          if (n > MAX_PARAMS) n = MAX_PARAMS;
          for (k = 0; k < n; k++) begin
            w             = '0;
            w.data_byte   = param_buf[k];
            w.param_index = k[4:0];
            w.status_code = ST_OK;
            w.servo_id    = rx_id;
            w.param_count = n[5:0];
            awaited_words.push_back(w);
          end
          close_packet(ST_OK, rx_id, 8'd0, n[5:0]);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] expv,
                             input logic [7:0] actv);
    if (actv !== expv) begin
      $display("t=%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
      fail_count++;
    end
  endtask

  task automatic take_word();
    res_t w;
    if (awaited_words.size() == 0) begin
      $display("t=%0t: unexpected word, expected none, actual kind %0h code %0h",
               $time, out_kind, out_status_code);
      fail_count++;
    end else begin
      w = awaited_words.pop_front();
      check_field("kind", 8'(w.kind), 8'(out_kind));
      check_field("data_byte", w.data_byte, out_data_byte);
      check_field("param_index", 8'(w.param_index), 8'(out_param_index));
      check_field("status_code", 8'(w.status_code), 8'(out_status_code));
      check_field("servo_id", w.servo_id, out_servo_id);
      check_field("servo_error", w.servo_error, out_servo_error);
      check_field("param_count", 8'(w.param_count), 8'(out_param_count));
      check_field("last", 8'(w.last), 8'(out_last));
    end
  endtask

  initial begin
    fail_count    = 0;
    awaited_count = 0;
    hunting       = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      want_id = 8'd1;
      max_len = 8'd64;
      req_len = 6'd2;
      phase   = HUNT_FF1;
      pos     = '0;
      sum     = '0;
      rx_id   = '0;
      rx_len  = '0;
      rx_err  = '0;
      foreach (param_buf[i]) param_buf[i] = '0;
      awaited_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXPECTED_ID:   want_id = cfg_data;
          CFG_MAX_TOTAL_LEN: max_len = cfg_data;
          CFG_REQUESTED_LEN: req_len = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte);
      if (out_valid && !out_stall) take_word();
    end
    awaited_count = awaited_words.size();
    hunting       = (phase == HUNT_FF1);
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds status packets, broken packets and noise bytes into the deframer
// under several register settings and idle patterns; the checker predicts
// and compares every result word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ssd_pkg::*;

  // write to this index must be ignored by the block
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [7:0] out_data_byte;
  logic [4:0] out_param_index;
  logic [2:0] out_status_code;
  logic [7:0] out_servo_id;
  logic [7:0] out_servo_error;
  logic [5:0] out_param_count;
  logic       out_last;

  int         fail_count;
  int         awaited_count;
  logic       hunting;

  // idle percentages of the sender and the receiver
  int         gap_pct;
  int         stall_pct;
  int         bytes_sent;

  // local copy of the id and total length registers, used only to shape the stimulus
  logic [7:0] cfg_id;
  logic [7:0] cfg_max;

  servo_status_packet_deframer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_param_index (out_param_index),
    .out_status_code (out_status_code),
    .out_servo_id    (out_servo_id),
    .out_servo_error (out_servo_error),
    .out_param_count (out_param_count),
    .out_last        (out_last)
  );

  ssd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_param_index (out_param_index),
    .out_status_code (out_status_code),
    .out_servo_id    (out_servo_id),
    .out_servo_error (out_servo_error),
    .out_param_count (out_param_count),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .awaited_count   (awaited_count),
    .hunting         (hunting)
  );

  // 20 ns clock; first rising edge at 10 ns
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: stall at random, changing only at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Hard limit: far above the slowest correct run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one byte and hold it until the deframer takes it. Idle gaps are
  // inserted before the byte; the byte stays put while stalled.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Drop valid at the next falling edge, after the last byte was taken
  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Hold the sender until every predicted word has come out
  task automatic pause_until_drained();
    drop_valid();
    while (awaited_count != 0) @(negedge clk);
  endtask

  // Bring the parser back to header hunt and let it drain, so that the
  // registers can be rewritten. Zero bytes always close a packet in time.
  task automatic settle();
    drop_valid();
    while (!hunting) begin
      send_byte(8'h00);
      drop_valid();
    end
    while (awaited_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] id, input logic [7:0] maxl,
                            input logic [7:0] req);
    cfg_write(CFG_EXPECTED_ID, id);
    cfg_write(CFG_MAX_TOTAL_LEN, maxl);
    cfg_write(CFG_REQUESTED_LEN, req);
    cfg_id  = id;
    cfg_max = maxl;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 45; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 45; end
      default: begin gap_pct = 35; stall_pct = 35; end
    endcase
  endtask

  // Send one packet with random parameters. Where the length byte already
  // closes the packet, stop after it, as the block does.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input logic [7:0] err, input logic bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         k;
    sum = id + len;
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(id);
    send_byte(len);
    if (len < MIN_LEN || int'(len) + 4 > int'(cfg_max) || int'(len) - 2 > MAX_PARAMS)
      return;
    send_byte(err);
    sum = sum + err;
    for (k = 0; k < int'(len) - 2; k++) begin
      b = 8'($urandom);
      send_byte(b);
      sum = sum + b;
    end
    b = ~sum;
    if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
    send_byte(b);
  endtask

  // Mostly well-formed packets with random content; the rest are broken
  // packets of every kind and loose noise bytes.
  task automatic random_packet();
    int         r;
    int         n;
    int         lim;
    logic [7:0] len;
    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PARAMS) : $urandom_range(0, 6);
    lim = int'(cfg_max) - 6;
    if (n > lim) n = lim;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_frame(cfg_id, 8'(n + 2), 8'h00, 1'b0);
    end else if (r < 63) begin
      send_frame(cfg_id, 8'(n + 2), 8'h00, 1'b1);
    end else if (r < 70) begin
      send_frame(cfg_id ^ 8'($urandom_range(1, 255)), 8'(n + 2), 8'h00, 1'b0);
    end else if (r < 77) begin
      send_frame(cfg_id, 8'(n + 2), 8'($urandom_range(1, 255)), 1'b0);
    end else if (r < 82) begin
      send_frame(cfg_id, 8'($urandom_range(0, 1)), 8'h00, 1'b0);
    end else if (r < 87) begin
      // too long by total length or by parameter count
      if ($urandom_range(0, 1) == 1)
        len = 8'($urandom_range(int'(cfg_max) - 3, 255));
      else
        len = 8'($urandom_range(MAX_PARAMS + 3, 255));
      send_frame(cfg_id, len, 8'h00, 1'b0);
    end else begin
      repeat ($urandom_range(1, 4))
        send_byte(($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom));
    end
  endtask

  initial begin
    int ph;
    int start;
    int pk;
    int maxl;

    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_EXPECTED_ID;
    cfg_data   = 8'h00;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    out_stall  = 1'b0;
    bytes_sent = 0;
    cfg_id     = 8'd1;
    cfg_max    = 8'd64;
    set_idle_mode(0);

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset values: id 1, total length 64, two params
    send_frame(8'd1, 8'd4, 8'h00, 1'b0);     // two params, all returned
    send_frame(8'd1, 8'd2, 8'h00, 1'b0);     // no params at all
    send_frame(8'd1, 8'd7, 8'h00, 1'b0);     // five params, clipped to two
    send_byte(8'h00);                        // bad first header byte
    send_byte(HDR_BYTE);
    send_byte(8'h7E);                        // bad second header byte
    send_frame(8'd1, 8'd5, 8'h00, 1'b1);     // checksum failure
    send_frame(8'hFE, 8'd4, 8'h00, 1'b0);    // id mismatch
    send_frame(8'd1, 8'd3, 8'h20, 1'b0);     // servo reports an error
    send_frame(8'd1, 8'd0, 8'h00, 1'b0);     // short length, zero
    send_frame(8'd1, 8'd1, 8'h00, 1'b0);     // short length, one
    send_frame(8'd1, 8'd61, 8'h00, 1'b0);    // total length over the limit
    send_frame(8'd1, 8'd255, 8'h00, 1'b0);   // largest length byte
    settle();

    // Widest setting: full parameter buffer, and one byte over it
    set_config(8'd0, 8'd255, 8'd32);
    send_frame(8'd0, 8'(MAX_PARAMS + 2), 8'h00, 1'b0);
    send_frame(8'd0, 8'(MAX_PARAMS + 3), 8'h00, 1'b0);
    settle();

    // Unknown index must not disturb anything; requested count above 32
    cfg_write(CFG_UNUSED, 8'hA5);
    cfg_write(CFG_REQUESTED_LEN, 8'd63);
    send_frame(8'd0, 8'd20, 8'h00, 1'b0);
    settle();

    // Tightest setting: only zero-parameter packets fit
    set_config(8'd253, 8'd6, 8'd0);
    send_frame(8'd253, 8'd2, 8'h00, 1'b0);
    send_frame(8'd253, 8'd3, 8'h00, 1'b0);
    send_frame(8'd253, 8'd2, 8'hFF, 1'b0);
    settle();

    // Random part: one register setting and one idle pattern per phase
    for (ph = 0; ph < 8; ph++) begin
      set_idle_mode(ph % 4);
      if (ph == 3)
        maxl = 6;
      else if (ph == 5)
        maxl = 255;
      else if ($urandom_range(0, 3) == 0)
        maxl = $urandom_range(6, 20);
      else
        maxl = $urandom_range(40, 255);
      set_config(8'($urandom_range(0, 253)), 8'(maxl),
                 (ph == 6) ? 8'd63 : 8'($urandom_range(0, 34)));
      start = bytes_sent;
      pk    = 0;
      while (bytes_sent - start < 5) begin
        random_packet();
        pk++;
        // hold the sender until the output side has caught up
        if (pk == 1 || $urandom_range(0, 14) == 0) pause_until_drained();
      end
      settle();
    end

    // Drain and give the verdict
    drop_valid();
    while (awaited_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### servo_status_packet_deframer.f
rtl/ssd_pkg.sv
rtl/ssd_ram.sv
rtl/ssd_ctrl.sv
rtl/ssd_dp.sv
rtl/servo_status_packet_deframer.sv
test/ssd_checker.sv
test/testbench.sv
